FILE: rtl/b58enc_pkg.sv
// shared types, constants and digit arithmetic for the base58 encoder
package b58enc_pkg;

  localparam int BYTE_W    = 8;
  localparam int CHAR_W    = 7;
  localparam int MAX_BYTES = 40;
  localparam int MAX_DIGITS = 64;
  localparam int OUT_LIMIT = 64;
  localparam int DIG_W     = 6;           // one base58 digit
  localparam int ADDR_W    = 6;           // digit store address
  localparam int DCNT_W    = 7;           // digit count, holds 64
  localparam int ZCNT_W    = 6;
  localparam int BCNT_W    = 6;
  localparam int KCNT_W    = 7;
  localparam int V_W       = DIG_W + BYTE_W;  // digit * 256 + carry
  localparam int RECIP_58  = 1129;        // floor(2^16 / 58)
  localparam int RECIP_SH  = 16;
  localparam logic [CHAR_W-1:0] CHAR_ONE = 7'h31;

  localparam logic [8*58-1:0] ALPHABET =
    "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_EXT,
    ST_EM_RD,
    ST_EM_OUT
  } state_t;

  typedef struct packed {
    logic [BYTE_W-1:0] q;
    logic [DIG_W-1:0]  r;
  } divmod_t;

  // v / 58 and v % 58 for v below 58 * 256: reciprocal estimate, one fix-up
  function automatic divmod_t div58(input logic [V_W-1:0] v);
    logic [V_W+11-1:0] prod;
    logic [BYTE_W-1:0] q_est;
    logic [V_W-1:0]    rem;
    divmod_t           res;
    prod  = (V_W+11)'(v) * (V_W+11)'(RECIP_58);
    q_est = prod[RECIP_SH +: BYTE_W];
    rem   = v - V_W'(q_est) * V_W'(58);
    if (rem >= V_W'(58)) begin
      res.q = q_est + BYTE_W'(1);
      res.r = DIG_W'(rem - V_W'(58));
    end else begin
      res.q = q_est;
      res.r = rem[DIG_W-1:0];
    end
    return res;
  endfunction

  // digit to ascii through the bitcoin alphabet
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIG_W'(58)) begin
      c = ALPHABET[8*(57 - int'(d)) +: CHAR_W];
    end else begin
      c = CHAR_ONE;
    end
    return c;
  endfunction

endpackage

FILE: rtl/b58enc_if.sv
// byte and character channels of the base58 encoder
interface b58enc_in_if;
  logic                              valid;
  logic                              ready;
  logic [b58enc_pkg::BYTE_W-1:0]     data_byte;
  logic                              end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b58enc_out_if;
  logic                              valid;
  logic                              ready;
  logic [b58enc_pkg::CHAR_W-1:0]     character;
  logic                              last;
  logic                              overflow;

  modport source (output valid, output character, output last, output overflow, input ready);
  modport sink   (input valid, input character, input last, input overflow, output ready);
endinterface

FILE: rtl/base58_encoder.sv
// base58 encoder top level: digit store walk per byte and character emission
//
//  channel  | dir | payload                          | beat when
//  ---------+-----+----------------------------------+-------------------------
//  in_ch    | in  | data_byte, end_of_message        | in_ch.valid & in_ch.ready
//  out_ch   | out | character, last, overflow        | out_ch.valid & out_ch.ready
//
//  a byte is accepted in ST_IDLE, then ST_WALK walks the stored digits (the read of
//  digit i+1 overlaps the write of digit i on the store's two ports), then
//  ST_EXT appends up to two carry digits and finishes; a closing byte then
//  emits each character through a store read, then an output load
//  rst_n is synchronous; the digit store itself is never cleared, the digit
//  count bounds every used read to entries already written in this message
//  a stalled out_ch holds emission in place; in_ch stays low until done
module base58_encoder (
  input  logic          clk,
  input  logic          rst_n,
  b58enc_in_if.sink     in_ch,
  b58enc_out_if.source  out_ch
);
  import b58enc_pkg::*;

  // digit store, little-endian base58, one write and one read port
  logic [DIG_W-1:0]  mem [MAX_DIGITS];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [DIG_W-1:0]  mem_wd;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_ra;
  logic [DIG_W-1:0]  rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_ra];
    end
  end

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;       // digit being walked
  logic [BYTE_W-1:0] carry_r, carry_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;     // significant digits
  logic [ZCNT_W-1:0] zpc_r, zpc_nxt;       // leading zero bytes
  logic              inpfx_r, inpfx_nxt;
  logic [BCNT_W-1:0] bcnt_r, bcnt_nxt;
  logic              ovf_r, ovf_nxt;       // something dropped this message
  logic              eom_r, eom_nxt;
  logic [KCNT_W-1:0] k_r, k_nxt;           // character index
  logic [KCNT_W-1:0] n_r, n_nxt;           // characters to emit
  logic              ovfo_r, ovfo_nxt;     // overflow flag for the string

  // output register
  logic              ovld_r, ovld_nxt;
  logic [CHAR_W-1:0] ochar_r, ochar_nxt;
  logic              olast_r, olast_nxt;
  logic              oovf_r, oovf_nxt;

  logic              in_beat;
  logic              slot_free;
  logic [V_W-1:0]    div_in;
  divmod_t           dm;
  logic [7:0]        total;
  logic [7:0]        pos_full;
  logic              ovf_now;

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign in_beat         = in_ch.valid && in_ch.ready;
  assign slot_free       = !ovld_r || out_ch.ready;
  assign out_ch.valid    = ovld_r;
  assign out_ch.character = ochar_r;
  assign out_ch.last     = olast_r;
  assign out_ch.overflow = oovf_r;

  // walk uses digit*256+carry, the carry tail uses the carry alone
  assign div_in = (state_r == ST_WALK) ? {rdata_r, carry_r} : V_W'(carry_r);
  assign dm     = div58(div_in);

  // string length and position of the digit for character k
  assign total    = 8'(zpc_r) + 8'(dcnt_r);
  assign pos_full = 8'(dcnt_r) + 8'(zpc_r) - 8'd1 - 8'(k_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      dcnt_r  <= '0;
      zpc_r   <= '0;
      inpfx_r <= 1'b1;
      bcnt_r  <= '0;
      ovf_r   <= 1'b0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dcnt_r  <= dcnt_nxt;
      zpc_r   <= zpc_nxt;
      inpfx_r <= inpfx_nxt;
      bcnt_r  <= bcnt_nxt;
      ovf_r   <= ovf_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  // datapath registers, meaningful only in the states that load them
  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    carry_r <= carry_nxt;
    eom_r   <= eom_nxt;
    k_r     <= k_nxt;
    n_r     <= n_nxt;
    ovfo_r  <= ovfo_nxt;
    ochar_r <= ochar_nxt;
    olast_r <= olast_nxt;
    oovf_r  <= oovf_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    carry_nxt = carry_r;
    dcnt_nxt  = dcnt_r;
    zpc_nxt   = zpc_r;
    inpfx_nxt = inpfx_r;
    bcnt_nxt  = bcnt_r;
    ovf_nxt   = ovf_r;
    eom_nxt   = eom_r;
    k_nxt     = k_r;
    n_nxt     = n_r;
    ovfo_nxt  = ovfo_r;
    ovld_nxt  = ovld_r && !out_ch.ready;
    ochar_nxt = ochar_r;
    olast_nxt = olast_r;
    oovf_nxt  = oovf_r;
    mem_we    = 1'b0;
    mem_wa    = '0;
    mem_wd    = '0;
    mem_re    = 1'b0;
    mem_ra    = '0;
    ovf_now   = ovf_r;

    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          eom_nxt = in_ch.end_of_message;
          if (bcnt_r < BCNT_W'(MAX_BYTES)) begin
            carry_nxt = in_ch.data_byte;
            bcnt_nxt  = bcnt_r + BCNT_W'(1);
            if (inpfx_r && (in_ch.data_byte == '0)) begin
              zpc_nxt = zpc_r + ZCNT_W'(1);
            end else begin
              inpfx_nxt = 1'b0;
            end
            if (dcnt_r != '0) begin
              mem_re    = 1'b1;
              mem_ra    = '0;
              idx_nxt   = '0;
              state_nxt = ST_WALK;
            end else begin
              state_nxt = ST_EXT;
            end
          end else begin
            // byte past the limit: dropped, its end marker still counts
            ovf_nxt   = 1'b1;
            carry_nxt = '0;
            state_nxt = ST_EXT;
          end
        end
      end

      ST_WALK: begin
        // rdata_r holds digit idx_r; write it back and fetch the next one
        mem_we    = 1'b1;
        mem_wa    = idx_r;
        mem_wd    = dm.r;
        carry_nxt = dm.q;
        if (DCNT_W'(idx_r) + DCNT_W'(1) < dcnt_r) begin
          mem_re  = 1'b1;
          mem_ra  = idx_r + ADDR_W'(1);
          idx_nxt = idx_r + ADDR_W'(1);
        end else begin
          state_nxt = ST_EXT;
        end
      end

      ST_EXT: begin
        if ((carry_r != '0) && (dcnt_r < DCNT_W'(MAX_DIGITS))) begin
          // grow the store by one digit
          mem_we    = 1'b1;
          mem_wa    = dcnt_r[ADDR_W-1:0];
          mem_wd    = dm.r;
          dcnt_nxt  = dcnt_r + DCNT_W'(1);
          carry_nxt = dm.q;
        end else begin
          // store full drops what carry is left
          if (carry_r != '0) begin
            ovf_now = 1'b1;
          end
          ovf_nxt = ovf_now;
          if (!eom_r) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt = '0;
            if (total > 8'(OUT_LIMIT)) begin
              n_nxt    = KCNT_W'(OUT_LIMIT);
              ovfo_nxt = 1'b1;
            end else begin
              n_nxt    = total[KCNT_W-1:0];
              ovfo_nxt = ovf_now;
            end
            if (total == '0) begin
              dcnt_nxt  = '0;
              zpc_nxt   = '0;
              inpfx_nxt = 1'b1;
              bcnt_nxt  = '0;
              ovf_nxt   = 1'b0;
              state_nxt = ST_IDLE;
            end else begin
              state_nxt = ST_EM_RD;
            end
          end
        end
      end

      ST_EM_RD: begin
        // leading ones ignore the read data
        mem_re    = 1'b1;
        mem_ra    = pos_full[ADDR_W-1:0];
        state_nxt = ST_EM_OUT;
      end

      ST_EM_OUT: begin
        if (slot_free) begin
          ovld_nxt  = 1'b1;
          ochar_nxt = (k_r < KCNT_W'(zpc_r)) ? CHAR_ONE : digit_char(rdata_r);
          olast_nxt = (k_r + KCNT_W'(1) == n_r);
          oovf_nxt  = ovfo_r;
          if (k_r + KCNT_W'(1) == n_r) begin
            // string done, back to the cleared message state
            dcnt_nxt  = '0;
            zpc_nxt   = '0;
            inpfx_nxt = 1'b1;
            bcnt_nxt  = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r + KCNT_W'(1);
            state_nxt = ST_EM_RD;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: test/base58_encoder_tb.sv
// self-checking testbench for the base58 encoder: directed and random byte messages against a built-in encoder
`timescale 1ns / 100ps

module base58_encoder_tb;
  import b58enc_pkg::*;

  // watchdog: cycles without any beat on either channel
  localparam int unsigned STALL_LIMIT = 2000;
  // long receiver hold-off, started on this output beat
  localparam int unsigned HOLD_AT     = 60;
  localparam int unsigned LONG_HOLD   = 300;
  // settle time once the last character is in
  localparam int unsigned TAIL_CYCLES = 150;
  // random part stops once this many bytes are queued
  localparam int unsigned RAND_BYTES  = 112;

  // one byte on the input channel; wait_drain holds it back until every
  // character still owed has been received
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              eom;
    logic              wait_drain;
  } byte_item_t;

  // one character beat as it should appear on the output channel
  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
    logic              overflow;
  } char_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  b58enc_in_if  in_ch ();
  b58enc_out_if out_ch ();

  base58_encoder u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  byte_item_t  pending_bytes[$];
  char_beat_t  owed_chars[$];
  int unsigned bytes_queued = 0;
  int unsigned bytes_sent   = 0;
  int unsigned chars_seen   = 0;
  int unsigned errors       = 0;

  // ---------------------------------------------------------------------------
  // encoder state kept alongside the block
  // ---------------------------------------------------------------------------
  string       b58_alphabet = "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
  logic [DIG_W-1:0] digit_mem [64];   // base58 digits, least significant first
  int unsigned digit_cnt;
  int unsigned zero_lead;             // leading zero bytes of this message
  bit          in_lead;
  int unsigned msg_bytes;
  bit          dropped;

  function automatic void clear_message();
    foreach (digit_mem[i]) digit_mem[i] = '0;
    digit_cnt = 0;
    zero_lead = 0;
    in_lead   = 1'b1;
    msg_bytes = 0;
    dropped   = 1'b0;
  endfunction

  // fold one accepted byte into the digit store; on end of message queue
  // the whole encoded string and start over
  function automatic void encode_byte(input logic [BYTE_W-1:0] b, input logic eom);
    int unsigned carry;
    int unsigned v;
    int unsigned n;
    int unsigned pos;
    bit          ovf;
    byte         ch;
    char_beat_t  beat;
    if (msg_bytes < MAX_BYTES) begin
      // store = store * 256 + b, carried up through the digits
      carry = b;
      for (int i = 0; i < digit_cnt; i++) begin
        v = digit_mem[i] * 256 + carry;
        digit_mem[i] = DIG_W'(v % 58);
        carry = v / 58;
      end
      // new most significant digits; past the store's end they are lost
      while (carry > 0) begin
        if (digit_cnt >= MAX_DIGITS) begin
          dropped = 1'b1;
          carry = 0;
        end else begin
          digit_mem[digit_cnt] = DIG_W'(carry % 58);
          digit_cnt++;
          carry = carry / 58;
        end
      end
      if (in_lead && b == '0) zero_lead = (zero_lead + 1) % 64;
      else in_lead = 1'b0;
      msg_bytes++;
    end else begin
      // too many bytes: dropped, but its end flag still closes the message
      dropped = 1'b1;
    end
    if (eom) begin
      n   = zero_lead + digit_cnt;
      ovf = dropped;
      if (n > OUT_LIMIT) begin
        n   = OUT_LIMIT;
        ovf = 1'b1;
      end
      // a '1' per leading zero byte, then digits from the top; a zero value
      // contributes no digit at all
      for (int k = 0; k < n; k++) begin
        if (k < zero_lead) begin
          beat.character = CHAR_W'(8'h31);
        end else begin
          pos = digit_cnt - 1 - (k - zero_lead);
          ch  = b58_alphabet.getc(int'(digit_mem[pos % 64]));
          beat.character = CHAR_W'(ch);
        end
        beat.last     = (k + 1 == n);
        beat.overflow = ovf;
        owed_chars = {owed_chars, beat};
      end
      clear_message();
    end
  endfunction

  // idle cycles before the next beat; every third band of beats runs with
  // no idling at all
  function automatic int unsigned draw_wait(input int unsigned idx, input int unsigned band);
    if ((idx / band) % 3 == 2) return 0;
    return $urandom_range(0, 10);
  endfunction

  task automatic queue_byte(input logic [BYTE_W-1:0] b, input logic eom,
                            input logic wait_drain);
    byte_item_t it;
    it.data_byte  = b;
    it.eom        = eom;
    it.wait_drain = wait_drain;
    pending_bytes = {pending_bytes, it};
    bytes_queued++;
  endtask

  // ---------------------------------------------------------------------------
  // byte sender: one beat at a time from the pending queue, with random gaps
  // ---------------------------------------------------------------------------
  int unsigned tx_gap;

  always @(posedge clk) begin : byte_sender
    byte_item_t nxt;
    if (!rst_n) begin
      in_ch.valid          <= 1'b0;
      in_ch.data_byte      <= '0;
      in_ch.end_of_message <= 1'b0;
      tx_gap               <= 0;
    end else begin
      // predict from the beat the block takes at this edge
      if (in_ch.valid && in_ch.ready) begin
        encode_byte(in_ch.data_byte, in_ch.end_of_message);
        bytes_sent++;
      end
      // channel free after this edge: next byte, a gap, or nothing
      if (!in_ch.valid || in_ch.ready) begin
        if (tx_gap != 0) begin
          tx_gap      <= tx_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_bytes.size() != 0 &&
                     !(pending_bytes[0].wait_drain && owed_chars.size() != 0)) begin
          nxt = pending_bytes.pop_front();
          in_ch.data_byte      <= nxt.data_byte;
          in_ch.end_of_message <= nxt.eom;
          in_ch.valid          <= 1'b1;
          tx_gap               <= draw_wait(bytes_sent, 16);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // character receiver: checks each beat against the oldest owed character
  // ---------------------------------------------------------------------------
  int unsigned rx_stall;

  always @(posedge clk) begin : char_receiver
    char_beat_t want;
    int unsigned n;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_stall     <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      if (owed_chars.size() == 0) begin
        $display("%0t: unexpected character beat 0x%02h last %0b overflow %0b", $time,
                 out_ch.character, out_ch.last, out_ch.overflow);
        errors++;
      end else begin
        want = owed_chars.pop_front();
        if (out_ch.character !== want.character) begin
          $display("%0t: character expected 0x%02h actual 0x%02h", $time,
                   want.character, out_ch.character);
          errors++;
        end
        if (out_ch.last !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, out_ch.last);
          errors++;
        end
        if (out_ch.overflow !== want.overflow) begin
          $display("%0t: overflow expected %0b actual %0b", $time,
                   want.overflow, out_ch.overflow);
          errors++;
        end
      end
      // one long hold-off mid run so the sender keeps offering into a stalled block
      n = (chars_seen == HOLD_AT) ? LONG_HOLD : draw_wait(chars_seen, 24);
      chars_seen++;
      rx_stall     <= n;
      out_ch.ready <= (n == 0);
    end else if (rx_stall != 0) begin
      rx_stall     <= rx_stall - 1;
      out_ch.ready <= (rx_stall == 1);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned rand_bytes;
    int unsigned len;
    int unsigned zeros;
    bit          first_rand;
    logic [BYTE_W-1:0] b;

    clear_message();

    // directed: single-byte extremes, the first two-digit value, all-zero
    // message, zeros in front of a value, zero inside a value, a wide value
    queue_byte(8'h00, 1'b1, 1'b0);
    queue_byte(8'hFF, 1'b1, 1'b0);
    queue_byte(8'h01, 1'b1, 1'b0);
    queue_byte(8'h39, 1'b1, 1'b0);
    queue_byte(8'h3A, 1'b1, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b1, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h01, 1'b1, 1'b0);
    queue_byte(8'h80, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b1, 1'b0);
    for (int i = 0; i < 4; i++) queue_byte(8'hFF, (i == 3), 1'b0);

    // random messages; the first one overruns the byte limit and waits for
    // the directed characters to drain before it starts
    rand_bytes = 0;
    first_rand = 1'b1;
    while (rand_bytes < RAND_BYTES) begin
      if (first_rand) len = MAX_BYTES + 3;
      else if ($urandom_range(0, 9) == 0) len = $urandom_range(20, MAX_BYTES + 6);
      else len = $urandom_range(1, 8);
      zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(1, len) : 0;
      for (int i = 0; i < len; i++) begin
        if (i < zeros) begin
          b = '0;
        end else begin
          case ($urandom_range(0, 7))
            0:       b = 8'h00;
            1:       b = 8'hFF;
            default: b = BYTE_W'($urandom_range(0, 255));
          endcase
        end
        queue_byte(b, (i == len - 1), first_rand && (i == 0));
      end
      rand_bytes += len;
      first_rand = 1'b0;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_sent != bytes_queued) @(posedge clk);
    while (owed_chars.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (owed_chars.size() != 0) begin
      $display("%0t: %0d characters never arrived", $time, owed_chars.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
